/* hw/rtl/gvrs_pkg.sv */
package gvrs_pkg;

    localparam int ANGLE_W = 10;
    localparam int GAIN_W  = 16;
    localparam int SUM_W   = 24;
    localparam int SLOT_W  = 8;
    localparam int SPK_W   = 5;
    localparam int COUNT_W = 9;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MERGE = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

/* hw/rtl/gvrs_ram.sv */
module gvrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/gain_vector_range_sum_core.sv */
// Range sum over a table of virtual sources.
//
// Input channel (s_*): one request is either a load (op 0) or a query (op 1).
// A load writes the angle index of one slot and one speaker gain of that slot.
// It does a read-modify-write of the slot's row (read, then written in ST_MERGE);
// an out of range slot or speaker is dropped in the accepting cycle. No result.
// A query scans slots 0 .. n-1, n = min(source_count, MAX_SOURCES), one row per
// cycle from the source RAM (one port read, registered output), summing all
// speaker lanes in parallel. It then emits SPEAKER_COUNT results (m_*), speaker
// 0 upward, m_last on the final one.
// The result register is separate from the input side: a new request is taken
// as soon as the last result of a query has entered it. A stall on m_ready
// holds the emit sequence and the block takes no request until it completes.
// Reset (aresetn low, synchronous) clears source_count and control state;
// RAM contents are undefined until loaded and are not cleared.
// source_count is written through cfg_wr_en/cfg_wr_data; the user must write it while the block is idle (not enforced).
module gain_vector_range_sum_core
    import gvrs_pkg::*;
#(
    parameter int MAX_SOURCES   = 256,
    parameter int SPEAKER_COUNT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [SLOT_W-1:0]  s_slot,
    input  logic [SPK_W-1:0]   s_speaker,
    input  logic [ANGLE_W-1:0] s_theta_index,
    input  logic [GAIN_W-1:0]  s_gain,
    input  logic [ANGLE_W-1:0] s_query_low,
    input  logic [ANGLE_W-1:0] s_query_high,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [SPK_W-1:0]   m_speaker_out,
    output logic [SUM_W-1:0]   m_gain_sum,
    output logic [COUNT_W-1:0] m_match_count,
    output logic               m_last
);

    localparam int AW     = $clog2(MAX_SOURCES);
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
    localparam int LANE_W = (SPEAKER_COUNT > 1) ? $clog2(SPEAKER_COUNT) : 1;
    localparam int ROW_W  = ANGLE_W + GAIN_W * SPEAKER_COUNT;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] source_count_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [ANGLE_W-1:0] lo_reg, lo_next;
    logic [ANGLE_W-1:0] hi_reg, hi_next;
    logic [AW-1:0]      ld_addr_reg, ld_addr_next;
    logic [SPK_W-1:0]   ld_spk_reg, ld_spk_next;
    logic [ANGLE_W-1:0] ld_theta_reg, ld_theta_next;
    logic [GAIN_W-1:0]  ld_gain_reg, ld_gain_next;
    logic [LANE_W-1:0]  emit_reg, emit_next;
    logic [SUM_W-1:0]   acc_reg [SPEAKER_COUNT];
    logic [SUM_W-1:0]   acc_next [SPEAKER_COUNT];

    logic               m_valid_reg, m_valid_next;
    logic [SPK_W-1:0]   m_speaker_reg, m_speaker_next;
    logic [SUM_W-1:0]   m_sum_reg, m_sum_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_last_reg, m_last_next;

    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [ROW_W-1:0]   ram_rd_data;
    logic               ram_wr_en;
    logic [ROW_W-1:0]   ram_wr_data;

    logic               out_free;
    logic               load_ok;
    logic               in_range;
    logic [CNT_W-1:0]   scan_len;
    logic [ANGLE_W-1:0] row_angle;
    logic [SUM_W:0]     lane_sum [SPEAKER_COUNT];

    // one row per slot: angle index in the low bits, then one gain per speaker
    gvrs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SOURCES)
    ) u_src_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ld_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_speaker_out = m_speaker_reg;
    assign m_gain_sum    = m_sum_reg;
    assign m_match_count = m_count_reg;
    assign m_last        = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign load_ok   = (32'(s_slot) < MAX_SOURCES) && (32'(s_speaker) < SPEAKER_COUNT);
    assign scan_len  = (32'(source_count_reg) > MAX_SOURCES) ? CNT_W'(MAX_SOURCES)
                                                             : CNT_W'(source_count_reg);
    assign row_angle = ram_rd_data[ANGLE_W-1:0];
    assign in_range  = (row_angle >= lo_reg) && (row_angle <= hi_reg);

    // merged row for a load: replace the angle and the addressed gain lane
    always_comb begin
        ram_wr_data = ram_rd_data;
        ram_wr_data[ANGLE_W-1:0] = ld_theta_reg;
        for (int l = 0; l < SPEAKER_COUNT; l++) begin
            if (32'(ld_spk_reg) == l) begin
                ram_wr_data[ANGLE_W + GAIN_W*l +: GAIN_W] = ld_gain_reg;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < SPEAKER_COUNT; l++) begin
            lane_sum[l] = {1'b0, acc_reg[l]}
                        + (SUM_W+1)'(ram_rd_data[ANGLE_W + GAIN_W*l +: GAIN_W]);
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ld_addr_next   = ld_addr_reg;
        ld_spk_next    = ld_spk_reg;
        ld_theta_next  = ld_theta_reg;
        ld_gain_next   = ld_gain_reg;
        emit_next      = emit_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_speaker_next = m_speaker_reg;
        m_sum_next     = m_sum_reg;
        m_count_next   = m_count_reg;
        m_last_next    = m_last_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = idx_reg[AW-1:0];
        ram_wr_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_QUERY) begin
                        idx_next   = '0;
                        cnt_next   = '0;
                        len_next   = scan_len;
                        lo_next    = s_query_low;
                        hi_next    = s_query_high;
                        for (int l = 0; l < SPEAKER_COUNT; l++) begin
                            acc_next[l] = '0;
                        end
                        state_next = ST_SCAN;
                    end else if (load_ok) begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = AW'(s_slot);
                        ld_addr_next  = AW'(s_slot);
                        ld_spk_next   = s_speaker;
                        ld_theta_next = s_theta_index;
                        ld_gain_next  = s_gain;
                        state_next    = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                // row read last cycle; no request taken until the write lands
                ram_wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (idx_reg != len_reg) begin
                    ram_rd_en   = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                if (rd_vld_reg && in_range) begin
                    cnt_next = cnt_reg + 1'b1;
                    for (int l = 0; l < SPEAKER_COUNT; l++) begin
                        acc_next[l] = lane_sum[l][SUM_W] ? SUM_MAX : lane_sum[l][SUM_W-1:0];
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_speaker_next = SPK_W'(emit_reg);
                    m_sum_next     = acc_reg[emit_reg];
                    m_count_next   = COUNT_W'(cnt_reg);
                    m_last_next    = (emit_reg == LANE_W'(SPEAKER_COUNT - 1));
                    if (emit_reg == LANE_W'(SPEAKER_COUNT - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            source_count_reg <= '0;
            idx_reg          <= '0;
            len_reg          <= '0;
            cnt_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            emit_reg         <= '0;
            m_valid_reg      <= 1'b0;
            for (int l = 0; l < SPEAKER_COUNT; l++) begin
                acc_reg[l] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            emit_reg   <= emit_next;
            m_valid_reg <= m_valid_next;
            acc_reg    <= acc_next;
            if (cfg_wr_en) begin
                source_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ld_addr_reg   <= ld_addr_next;
        ld_spk_reg    <= ld_spk_next;
        ld_theta_reg  <= ld_theta_next;
        ld_gain_reg   <= ld_gain_next;
        m_speaker_reg <= m_speaker_next;
        m_sum_reg     <= m_sum_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= len_reg))
        else $error("scan index beyond scan length");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (cnt_reg <= len_reg))
        else $error("match count exceeds scanned rows");

    a_write_isolated: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (!rd_vld_reg && $past(ram_rd_en)))
        else $error("row write without its preceding read");

    a_last_speaker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_speaker_out == SPK_W'(SPEAKER_COUNT - 1)))
        else $error("last flag on wrong speaker");

    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_QUERY) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("query did not start a clean scan");

endmodule
